[sv/sht_pkg.sv]
// ----------------------------------------------------------------
// sht_pkg
// shared types, codes and helpers of the syslog header field tagger
// ----------------------------------------------------------------
package sht_pkg;

    // default depth of the request queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // results one request can cause (held bytes plus the current byte)
    localparam int MAX_RESULTS = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] PRI_MAX  = 8'd191;
    localparam logic [7:0] PRI_SAT  = 8'd255;

    typedef enum logic [3:0] {
        TAG_PRI     = 4'd0,
        TAG_VER     = 4'd1,
        TAG_TIME    = 4'd2,
        TAG_HOST    = 4'd3,
        TAG_APP     = 4'd4,
        TAG_PROCID  = 4'd5,
        TAG_MSGID   = 4'd6,
        TAG_SD      = 4'd7,
        TAG_TEXT    = 4'd8,
        TAG_SEP     = 4'd9,
        TAG_DISC    = 4'd10
    } tag_t;

    typedef enum logic [4:0] {
        PH_OPEN       = 5'd0,
        PH_PRI        = 5'd1,
        PH_FIRST      = 5'd2,
        PH_VERSION    = 5'd3,
        PH_TSTAMP     = 5'd4,
        PH_HOSTNAME   = 5'd5,
        PH_APP        = 5'd6,
        PH_PROCID     = 5'd7,
        PH_MSGID      = 5'd8,
        PH_SD         = 5'd9,
        PH_TEXT       = 5'd10,
        PH_MONTH      = 5'd11,
        PH_TIME_SKIP  = 5'd12,
        PH_TIME       = 5'd13,
        PH_END_SKIP   = 5'd14,
        PH_HOST       = 5'd15,
        PH_HOSTFIRST  = 5'd16,
        PH_DISCARD    = 5'd17
    } phase_t;

    typedef enum logic [2:0] {
        SD_START = 3'd0,
        SD_ELEM  = 3'd1,
        SD_QUOTE = 3'd2,
        SD_AFTER = 3'd3,
        SD_NIL   = 3'd4
    } sd_state_t;

    // one request as classified by the front: up to four tagged bytes
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        tag_t [MAX_RESULTS-1:0]      tags;
        logic [1:0]                  last_idx;
        logic [2:0]                  severity;
        logic [4:0]                  facility;
        logic [2:0]                  log_level;
        logic                        is_bsd;
        logic                        header_error;
        logic                        last;
    } sht_bundle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // severity to log level: 0,1 fatal, then one step per severity
    function automatic logic [2:0] level_of(input logic [2:0] sev);
        return (sev == 3'd0) ? 3'd0 : 3'(sev - 3'd1);
    endfunction

endpackage

[sv/sht_in_if.sv]
// ----------------------------------------------------------------
// sht_in_if
// byte channel into the tagger
// ----------------------------------------------------------------
interface sht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output end_of_message, input ready);
    modport sink   (input valid, input msg_byte, input end_of_message, output ready);
endinterface

[sv/sht_out_if.sv]
// ----------------------------------------------------------------
// sht_out_if
// tagged byte channel out of the tagger
// ----------------------------------------------------------------
interface sht_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [3:0] field_tag;
    logic [2:0] severity;
    logic [4:0] facility;
    logic [2:0] log_level;
    logic       is_bsd;
    logic       header_error;
    logic       last_out;

    modport source (output valid, output out_byte, output field_tag, output severity,
                    output facility, output log_level, output is_bsd,
                    output header_error, output last_out, input ready);
    modport sink   (input valid, input out_byte, input field_tag, input severity,
                    input facility, input log_level, input is_bsd,
                    input header_error, input last_out, output ready);
endinterface

[sv/sht_front.sv]
// ----------------------------------------------------------------
// sht_front
// header parser: classifies each byte request into a bundle of tagged bytes
// ----------------------------------------------------------------
module sht_front (
    input  logic                clk,
    input  logic                rst_n,
    sht_in_if.sink              msg_in,
    input  logic                q_full,
    output logic                push,
    output sht_pkg::sht_bundle_t push_data
);
    import sht_pkg::*;

    phase_t     phase_reg, phase_next, ph_s;
    logic [7:0] pri_reg, pri_next, pri_s;
    logic       seen_reg, seen_next, seen_s;
    logic [2:0] sev_reg, sev_next, sev_s;
    logic [4:0] fac_reg, fac_next, fac_s;
    logic       bsd_reg, bsd_next, bsd_s;
    logic       err_reg, err_next, err_s;
    logic [1:0] tok_reg, tok_next, tok_s;
    logic [1:0] spc_reg, spc_next, spc_s;
    sd_state_t  sd_reg, sd_next, sd_s;
    logic [1:0][7:0] prev_reg;
    logic [2:0][7:0] held_reg;

    logic       accept;
    logic [7:0] b;
    logic       eom;
    logic       put;
    logic [1:0] flush_n;
    tag_t       flush_tag;
    tag_t       cur_tag;
    logic       do_month;
    logic       do_host;
    logic [1:0] tl_eff;
    logic       held_we;
    logic [1:0] held_idx;
    logic [11:0] pri_acc;
    logic       day_ok;
    logic       closed;

    assign msg_in.ready = !q_full;
    assign accept       = msg_in.valid && !q_full;
    assign b            = msg_in.msg_byte;
    assign eom          = msg_in.end_of_message;
    assign pri_acc      = 12'(pri_reg) * 12'd10 + 12'(b[3:0]);
    assign day_ok       = is_digit(prev_reg[0]) && (is_digit(prev_reg[1]) || is_ws(prev_reg[1]));

    always_comb
    begin
        ph_s      = phase_reg;
        pri_s     = pri_reg;
        seen_s    = seen_reg;
        sev_s     = sev_reg;
        fac_s     = fac_reg;
        bsd_s     = bsd_reg;
        err_s     = err_reg;
        tok_s     = tok_reg;
        spc_s     = spc_reg;
        sd_s      = sd_reg;
        put       = 1'b1;
        flush_n   = 2'd0;
        flush_tag = TAG_TIME;
        cur_tag   = TAG_DISC;
        do_month  = 1'b0;
        do_host   = 1'b0;
        tl_eff    = tok_reg;
        held_we   = 1'b0;
        held_idx  = tok_reg;

        case (phase_reg)
            PH_OPEN:
            begin
                if (b == CH_LT)
                begin
                    ph_s    = PH_PRI;
                    cur_tag = TAG_PRI;
                end
                else
                begin
                    err_s = 1'b1;
                    ph_s  = PH_DISCARD;
                end
            end
            PH_PRI:
            begin
                if (is_digit(b))
                begin
                    pri_s   = (pri_acc > 12'(PRI_SAT)) ? PRI_SAT : pri_acc[7:0];
                    seen_s  = 1'b1;
                    cur_tag = TAG_PRI;
                end
                else if (b == CH_GT && seen_reg && pri_reg <= PRI_MAX)
                begin
                    sev_s   = pri_reg[2:0];
                    fac_s   = pri_reg[7:3];
                    ph_s    = PH_FIRST;
                    cur_tag = TAG_PRI;
                end
                else
                begin
                    err_s = 1'b1;
                    ph_s  = PH_DISCARD;
                end
            end
            PH_FIRST:
            begin
                if (is_digit(b))
                begin
                    ph_s    = PH_VERSION;
                    cur_tag = TAG_VER;
                end
                else
                begin
                    // old form: the byte goes straight into the month token
                    bsd_s    = 1'b1;
                    ph_s     = PH_MONTH;
                    tl_eff   = 2'd0;
                    do_month = 1'b1;
                end
            end
            PH_VERSION, PH_TSTAMP, PH_HOSTNAME, PH_APP, PH_PROCID, PH_MSGID:
            begin
                if (is_ws(b))
                begin
                    sd_s    = SD_START;
                    cur_tag = TAG_SEP;
                    case (phase_reg)
                        PH_VERSION:  ph_s = PH_TSTAMP;
                        PH_TSTAMP:   ph_s = PH_HOSTNAME;
                        PH_HOSTNAME: ph_s = PH_APP;
                        PH_APP:      ph_s = PH_PROCID;
                        PH_PROCID:   ph_s = PH_MSGID;
                        default:     ph_s = PH_SD;
                    endcase
                end
                else
                begin
                    case (phase_reg)
                        PH_VERSION:  cur_tag = TAG_VER;
                        PH_TSTAMP:   cur_tag = TAG_TIME;
                        PH_HOSTNAME: cur_tag = TAG_HOST;
                        PH_APP:      cur_tag = TAG_APP;
                        PH_PROCID:   cur_tag = TAG_PROCID;
                        default:     cur_tag = TAG_MSGID;
                    endcase
                end
            end
            PH_SD:
            begin
                cur_tag = TAG_SD;
                if (sd_reg == SD_ELEM)
                begin
                    if (b == CH_QUOTE)
                        sd_s = SD_QUOTE;
                    else if (b == CH_RBR)
                        sd_s = SD_AFTER;
                end
                else if (sd_reg == SD_QUOTE)
                begin
                    if (b == CH_QUOTE)
                        sd_s = SD_ELEM;
                end
                else if (sd_reg == SD_START && b == CH_DASH)
                begin
                    sd_s = SD_NIL;
                end
                else if ((sd_reg == SD_START || sd_reg == SD_AFTER) && b == CH_LBR)
                begin
                    sd_s = SD_ELEM;
                end
                else
                begin
                    ph_s    = PH_TEXT;
                    sd_s    = SD_START;
                    cur_tag = is_ws(b) ? TAG_SEP : TAG_TEXT;
                end
            end
            PH_TEXT:
            begin
                cur_tag = TAG_TEXT;
            end
            PH_MONTH:
            begin
                do_month = 1'b1;
            end
            PH_TIME_SKIP:
            begin
                // every byte, a space included, is an ordinary time byte here
                ph_s    = PH_TIME;
                cur_tag = TAG_TIME;
            end
            PH_TIME:
            begin
                if (b == CH_SPACE)
                begin
                    if (spc_reg == 2'd1 && day_ok)
                    begin
                        spc_s   = 2'd2;
                        ph_s    = PH_TIME_SKIP;
                        cur_tag = TAG_TIME;
                    end
                    else
                    begin
                        ph_s    = PH_END_SKIP;
                        cur_tag = TAG_SEP;
                    end
                end
                else
                begin
                    cur_tag = TAG_TIME;
                end
            end
            PH_END_SKIP:
            begin
                ph_s = PH_HOST;
                if (b == CH_SPACE)
                    cur_tag = TAG_SEP;
                else
                    do_host = 1'b1;
            end
            PH_HOST:
            begin
                do_host = 1'b1;
            end
            PH_HOSTFIRST:
            begin
                if (b == CH_SPACE)
                begin
                    ph_s    = PH_TEXT;
                    cur_tag = TAG_SEP;
                end
                else
                begin
                    cur_tag = TAG_HOST;
                end
            end
            default:
            begin
                cur_tag = TAG_DISC;
            end
        endcase

        if (do_host)
        begin
            if (is_ws(b))
            begin
                ph_s    = PH_TEXT;
                cur_tag = TAG_SEP;
            end
            else
            begin
                cur_tag = TAG_HOST;
            end
        end

        if (do_month)
        begin
            if (b == CH_SPACE)
            begin
                flush_n = tl_eff;
                tok_s   = 2'd0;
                if (tl_eff == 2'd3)
                begin
                    flush_tag = TAG_TIME;
                    cur_tag   = TAG_TIME;
                    spc_s     = 2'd1;
                    ph_s      = PH_TIME_SKIP;
                end
                else
                begin
                    flush_tag = TAG_HOST;
                    cur_tag   = TAG_SEP;
                    ph_s      = PH_TEXT;
                end
            end
            else if (tl_eff != 2'd3)
            begin
                if (eom)
                begin
                    // early end: held bytes go out as time
                    flush_n   = tl_eff;
                    flush_tag = TAG_TIME;
                    cur_tag   = TAG_TIME;
                    tok_s     = 2'd0;
                end
                else
                begin
                    put      = 1'b0;
                    held_we  = 1'b1;
                    held_idx = tl_eff;
                    tok_s    = 2'(tl_eff + 2'd1);
                end
            end
            else
            begin
                flush_n   = 2'd3;
                flush_tag = TAG_HOST;
                cur_tag   = TAG_HOST;
                tok_s     = 2'd0;
                ph_s      = PH_HOSTFIRST;
            end
        end
    end

    // all results of one request see the same header flags
    assign closed = (ph_s != PH_OPEN) && (ph_s != PH_PRI) && !err_s;

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS - 1; i++)
        begin
            push_data.bytes[i] = (2'(i) < flush_n) ? held_reg[i] : b;
            push_data.tags[i]  = (2'(i) < flush_n) ? flush_tag : cur_tag;
        end
        push_data.bytes[MAX_RESULTS-1] = b;
        push_data.tags[MAX_RESULTS-1]  = cur_tag;
        push_data.last_idx     = flush_n;
        push_data.severity     = closed ? sev_s : 3'd0;
        push_data.facility     = closed ? fac_s : 5'd0;
        push_data.log_level    = closed ? level_of(sev_s) : 3'd0;
        push_data.is_bsd       = bsd_s;
        push_data.header_error = err_s;
        push_data.last         = eom;
    end

    assign push = accept && put;

    // end of message puts the parser back to its start values
    always_comb
    begin
        if (eom)
        begin
            phase_next = PH_OPEN;
            pri_next   = 8'd0;
            seen_next  = 1'b0;
            sev_next   = 3'd0;
            fac_next   = 5'd0;
            bsd_next   = 1'b0;
            err_next   = 1'b0;
            tok_next   = 2'd0;
            spc_next   = 2'd0;
            sd_next    = SD_START;
        end
        else
        begin
            phase_next = ph_s;
            pri_next   = pri_s;
            seen_next  = seen_s;
            sev_next   = sev_s;
            fac_next   = fac_s;
            bsd_next   = bsd_s;
            err_next   = err_s;
            tok_next   = tok_s;
            spc_next   = spc_s;
            sd_next    = sd_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            pri_reg   <= 8'd0;
            seen_reg  <= 1'b0;
            sev_reg   <= 3'd0;
            fac_reg   <= 5'd0;
            bsd_reg   <= 1'b0;
            err_reg   <= 1'b0;
            tok_reg   <= 2'd0;
            spc_reg   <= 2'd0;
            sd_reg    <= SD_START;
            prev_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pri_reg   <= pri_next;
            seen_reg  <= seen_next;
            sev_reg   <= sev_next;
            fac_reg   <= fac_next;
            bsd_reg   <= bsd_next;
            err_reg   <= err_next;
            tok_reg   <= tok_next;
            spc_reg   <= spc_next;
            sd_reg    <= sd_next;
            prev_reg  <= {prev_reg[0], b};
        end
    end

    // held month bytes are payload only
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
            held_reg[held_idx] <= b;
    end

    a_tok_only_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_MONTH) |-> (tok_reg == 2'd0))
        else $error("held bytes outside month token");

    a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (phase_reg == PH_DISCARD))
        else $error("error flag without discard phase");

    a_bsd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        bsd_reg |-> (phase_reg >= PH_TEXT))
        else $error("bsd flag in a new format phase");
endmodule

[sv/sht_queue.sv]
// ----------------------------------------------------------------
// sht_queue
// short bundle queue between parser front and output back
// ----------------------------------------------------------------
module sht_queue #(
    parameter int DEPTH = sht_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sht_pkg::sht_bundle_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output sht_pkg::sht_bundle_t head
);
    import sht_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sht_bundle_t [DEPTH-1:0] slot_reg;
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_reg + 1'b1);
        if (pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_reg + 1'b1);
        if (push && !pop)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
endmodule

[sv/sht_back.sv]
// ----------------------------------------------------------------
// sht_back
// unpacks queued bundles into one tagged byte per cycle while tag_out is ready
// ----------------------------------------------------------------
module sht_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sht_pkg::sht_bundle_t head,
    output logic                 pop,
    sht_out_if.source            tag_out
);
    import sht_pkg::*;

    logic       valid_reg;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg;
    logic [3:0] tag_reg;
    logic [2:0] sev_reg;
    logic [4:0] fac_reg;
    logic [2:0] lvl_reg;
    logic       bsd_reg;
    logic       err_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load   = q_valid && (!valid_reg || tag_out.ready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = at_end ? 2'd0 : 2'(idx_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                valid_reg <= 1'b1;
            else if (tag_out.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            tag_reg  <= head.tags[idx_reg];
            sev_reg  <= head.severity;
            fac_reg  <= head.facility;
            lvl_reg  <= head.log_level;
            bsd_reg  <= head.is_bsd;
            err_reg  <= head.header_error;
            last_reg <= head.last && at_end;
        end
    end

    assign tag_out.valid        = valid_reg;
    assign tag_out.out_byte     = byte_reg;
    assign tag_out.field_tag    = tag_reg;
    assign tag_out.severity     = sev_reg;
    assign tag_out.facility     = fac_reg;
    assign tag_out.log_level    = lvl_reg;
    assign tag_out.is_bsd       = bsd_reg;
    assign tag_out.header_error = err_reg;
    assign tag_out.last_out     = last_reg;

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg <= head.last_idx))
        else $error("unpack index past end of bundle");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == 2'd0))
        else $error("unpack index left over with empty queue");
endmodule

[sv/syslog_header_field_tagger.sv]
// ----------------------------------------------------------------
// syslog_header_field_tagger
// tags each syslog message byte with its header field
// ----------------------------------------------------------------
// usage
//   msg_in carries one message byte per request, with end_of_message on the
//   final byte; tag_out returns every byte once, in order, with its field
//   tag, the decoded pri values, the format and error flags and last_out
//   on the final byte of the message
//   a byte accepted from msg_in is written into the queue and then into the
//   output register before it appears on tag_out; the first three bytes of a
//   bsd month token are held back until the following byte decides whether
//   they are time or host; the front parser takes a byte every cycle while
//   the queue is not full and writes up to four tagged bytes as one bundle
//   into the queue, the back unpacks one tagged byte a cycle into the output
//   register while tag_out is ready; one message byte yields one result on
//   average; when tag_out stalls the queue fills and msg_in.ready falls once
//   it is full; nothing is lost or repeated
//   reset empties the queue, clears the output valid flag and puts the parser
//   back to expecting the opening angle bracket
// ----------------------------------------------------------------
module syslog_header_field_tagger #(
    parameter int QUEUE_DEPTH = sht_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    sht_in_if.sink     msg_in,
    sht_out_if.source  tag_out
);
    import sht_pkg::*;

    // front to queue
    logic        push;
    sht_bundle_t push_data;
    logic        q_full;

    // queue to back
    logic        q_valid;
    logic        pop;
    sht_bundle_t head;

    // parser: pri, format choice, field phases, held month bytes
    sht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (msg_in),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // decouples the parser from output stalls
    sht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    // one tagged byte per cycle into the output register while tag_out is ready
    sht_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .tag_out (tag_out)
    );
endmodule
